/* rtl/gao_pkg.sv */
// Shared constants, types and arithmetic helpers for the gray-alpha compositor.
package gao_pkg;

	// Channel full scale and rounding offset for the divisions by full scale
	localparam int unsigned CHANNEL_MAX = 255;
	localparam int unsigned HALF_MAX    = CHANNEL_MAX / 2;

	// Pipeline depth: six blend stages, five un-premultiply stages
	localparam int unsigned BLEND_STAGES = 6;
	localparam int unsigned NORM_STAGES  = 5;
	localparam int unsigned NSTAGE       = BLEND_STAGES + NORM_STAGES;

	// Configuration register indexes
	localparam logic CFG_BLEND_MODE    = 1'b0;
	localparam logic CFG_LAYER_OPACITY = 1'b1;

	// Blend modes; the unused code falls through to over
	typedef enum logic [1:0] {
		MODE_OVER  = 2'd0,
		MODE_COPY  = 2'd1,
		MODE_CLEAR = 2'd2
	} blend_mode_t;

	// Per-stage load enables from the pipeline control
	typedef struct packed {
		logic [NSTAGE-1:0] ld;
	} pipe_ctrl_t;

	// Pixel handed from the blend stages to the un-premultiply stages
	typedef struct packed {
		logic       norm;
		logic [7:0] gray;
		logic [7:0] alpha;
	} pix_t;

	// Floor division by 255 of a 17-bit value: estimate, then one correction
	function automatic logic [9:0] div255(input logic [16:0] x);
		logic [17:0] sum;
		logic [9:0]  q;
		logic [17:0] qm;
		logic [17:0] r;
		sum = {1'b0, x} + {9'b0, x[16:8]};
		q   = sum[17:8];
		qm  = {q, 8'b0} - {8'b0, q};
		r   = {1'b0, x} - qm;
		if (r >= 18'(CHANNEL_MAX)) begin
			q = q + 10'd1;
		end
		return q;
	endfunction

	// Saturate at full scale
	function automatic logic [7:0] sat8(input logic [9:0] v);
		logic [7:0] res;
		res = (v > 10'(CHANNEL_MAX)) ? 8'(CHANNEL_MAX) : v[7:0];
		return res;
	endfunction

endpackage

/* rtl/gao_pipe_ctrl.sv */
// Valid bits and per-stage load enables of the compositor pipeline.
module gao_pipe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output gao_pkg::pipe_ctrl_t ctrl
);

	logic [gao_pkg::NSTAGE-1:0] valid_q;
	logic [gao_pkg::NSTAGE-1:0] ld;

	// Advance a stage when it is empty or the stage after it advances
	always_comb begin
		ld[gao_pkg::NSTAGE-1] = !valid_q[gao_pkg::NSTAGE-1] || out_ready;
		for (int i = gao_pkg::NSTAGE - 2; i >= 0; i--) begin
			ld[i] = !valid_q[i] || ld[i+1];
		end
	end

	// Move valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ld[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int i = 1; i < gao_pkg::NSTAGE; i++) begin
				if (ld[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	assign ctrl.ld    = ld;
	assign in_ready   = ld[0];
	assign out_valid  = valid_q[gao_pkg::NSTAGE-1];

endmodule

/* rtl/gao_blend.sv */
// Mode decode and over blending with rounded divisions by full scale (stages 1 to 6).
module gao_blend (
	input  logic                clk,
	input  gao_pkg::pipe_ctrl_t ctrl,
	input  logic [1:0]          blend_mode,
	input  logic [7:0]          layer_opacity,
	input  logic [7:0]          src_gray,
	input  logic [7:0]          src_alpha,
	input  logic [7:0]          dst_gray,
	input  logic [7:0]          dst_alpha,
	output gao_pkg::pix_t       pix
);

	localparam logic [7:0]  FULL = 8'(gao_pkg::CHANNEL_MAX);
	localparam logic [16:0] HALF = 17'(gao_pkg::HALF_MAX);

	// Stage 1: decode the pass-through cases, scale source alpha by opacity
	logic        byp_s1;
	logic [7:0]  bg_s1, ba_s1, sg_s1, sa_s1, dg_s1, da_s1;
	logic        full_s1;
	logic [16:0] psa_s1;
	logic        byp_d;
	logic [7:0]  bg_d, ba_d;

	always_comb begin
		byp_d = 1'b0;
		bg_d  = dst_gray;
		ba_d  = dst_alpha;
		if (blend_mode == gao_pkg::MODE_COPY) begin
			byp_d = 1'b1;
			bg_d  = src_gray;
			ba_d  = src_alpha;
		end else if (blend_mode == gao_pkg::MODE_CLEAR) begin
			byp_d = 1'b1;
			bg_d  = '0;
			ba_d  = '0;
		end else if (layer_opacity == '0 || src_alpha == '0) begin
			byp_d = 1'b1;
		end else if (layer_opacity == FULL && (dst_alpha == '0 || src_alpha == FULL)) begin
			byp_d = 1'b1;
			bg_d  = src_gray;
			ba_d  = src_alpha;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld[0]) begin
			byp_s1  <= byp_d;
			bg_s1   <= bg_d;
			ba_s1   <= ba_d;
			sg_s1   <= src_gray;
			sa_s1   <= src_alpha;
			dg_s1   <= dst_gray;
			da_s1   <= dst_alpha;
			full_s1 <= (layer_opacity == FULL);
			psa_s1  <= ({9'b0, src_alpha} * {9'b0, layer_opacity}) + HALF;
		end
	end

	// Stage 2: effective source alpha and its complement
	logic       byp_s2;
	logic [7:0] bg_s2, ba_s2, sg_s2, sa_s2, ms_s2, dg_s2, da_s2;
	logic [7:0] sa_d;

	assign sa_d = full_s1 ? sa_s1 : gao_pkg::sat8(gao_pkg::div255(psa_s1));

	always_ff @(posedge clk) begin
		if (ctrl.ld[1]) begin
			byp_s2 <= byp_s1;
			bg_s2  <= bg_s1;
			ba_s2  <= ba_s1;
			sg_s2  <= sg_s1;
			sa_s2  <= sa_d;
			ms_s2  <= FULL - sa_d;
			dg_s2  <= dg_s1;
			da_s2  <= da_s1;
		end
	end

	// Stage 3: destination weight and new alpha numerators, source gray product
	logic        byp_s3;
	logic [7:0]  bg_s3, ba_s3, dg_s3;
	logic [16:0] pdw_s3, pa_s3;
	logic [15:0] psg_s3;
	logic [15:0] dams;
	logic [15:0] sam;

	assign dams = da_s2 * ms_s2;
	assign sam  = {sa_s2, 8'b0} - {8'b0, sa_s2};

	always_ff @(posedge clk) begin
		if (ctrl.ld[2]) begin
			byp_s3 <= byp_s2;
			bg_s3  <= bg_s2;
			ba_s3  <= ba_s2;
			dg_s3  <= dg_s2;
			pdw_s3 <= {1'b0, dams} + HALF;
			pa_s3  <= {1'b0, dams} + {1'b0, sam} + HALF;
			psg_s3 <= sg_s2 * sa_s2;
		end
	end

	// Stage 4: divide destination weight and new alpha
	logic        byp_s4;
	logic [7:0]  bg_s4, ba_s4, dg_s4, dw_s4, a_s4;
	logic [15:0] psg_s4;

	always_ff @(posedge clk) begin
		if (ctrl.ld[3]) begin
			byp_s4 <= byp_s3;
			bg_s4  <= bg_s3;
			ba_s4  <= ba_s3;
			dg_s4  <= dg_s3;
			dw_s4  <= gao_pkg::sat8(gao_pkg::div255(pdw_s3));
			a_s4   <= gao_pkg::sat8(gao_pkg::div255(pa_s3));
			psg_s4 <= psg_s3;
		end
	end

	// Stage 5: premultiplied gray numerator
	logic        byp_s5;
	logic [7:0]  bg_s5, ba_s5, a_s5;
	logic [16:0] pg_s5;
	logic [15:0] dgw;

	assign dgw = dg_s4 * dw_s4;

	always_ff @(posedge clk) begin
		if (ctrl.ld[4]) begin
			byp_s5 <= byp_s4;
			bg_s5  <= bg_s4;
			ba_s5  <= ba_s4;
			a_s5   <= a_s4;
			pg_s5  <= {1'b0, dgw} + {1'b0, psg_s4} + HALF;
		end
	end

	// Stage 6: divide gray and pick the blended or pass-through pixel
	gao_pkg::pix_t pix_s6;
	logic [7:0]    g_d;

	assign g_d = gao_pkg::sat8(gao_pkg::div255(pg_s5));

	always_ff @(posedge clk) begin
		if (ctrl.ld[5]) begin
			pix_s6.norm  <= !byp_s5 && (a_s5 != '0);
			pix_s6.gray  <= byp_s5 ? bg_s5 : g_d;
			pix_s6.alpha <= byp_s5 ? ba_s5 : a_s5;
		end
	end

	assign pix = pix_s6;

endmodule

/* rtl/gao_unpremul.sv */
// Un-premultiply gray by the new alpha: restoring divider, two quotient bits a stage (stages 7 to 11).
module gao_unpremul (
	input  logic                clk,
	input  gao_pkg::pipe_ctrl_t ctrl,
	input  gao_pkg::pix_t       pix,
	output logic [7:0]          out_gray,
	output logic [7:0]          out_alpha
);

	localparam int unsigned S0 = gao_pkg::BLEND_STAGES;

	typedef struct packed {
		logic [7:0] rem;
		logic [7:0] lo;
		logic [7:0] q;
	} div_t;

	// Two restoring steps of gray*255 / alpha
	function automatic div_t step2(input div_t s, input logic [7:0] d);
		div_t       r;
		logic [8:0] t;
		r = s;
		for (int k = 0; k < 2; k++) begin
			t = {r.rem, r.lo[7]};
			r.lo = {r.lo[6:0], 1'b0};
			if (t >= {1'b0, d}) begin
				t   = t - {1'b0, d};
				r.q = {r.q[6:0], 1'b1};
			end else begin
				r.q = {r.q[6:0], 1'b0};
			end
			r.rem = t[7:0];
		end
		return r;
	endfunction

	// Stage 7: form gray*255, flag quotients that saturate
	logic        norm_s7, sat_s7;
	logic [7:0]  g_s7, a_s7;
	div_t        dv_s7;
	logic [15:0] num;

	assign num = {pix.gray, 8'b0} - {8'b0, pix.gray};

	always_ff @(posedge clk) begin
		if (ctrl.ld[S0]) begin
			norm_s7 <= pix.norm;
			sat_s7  <= (pix.gray >= pix.alpha);
			g_s7    <= pix.gray;
			a_s7    <= pix.alpha;
			dv_s7   <= '{rem: num[15:8], lo: num[7:0], q: 8'b0};
		end
	end

	// Stages 8 to 10: two quotient bits each
	logic       norm_s8, sat_s8, norm_s9, sat_s9, norm_s10, sat_s10;
	logic [7:0] g_s8, a_s8, g_s9, a_s9, g_s10, a_s10;
	div_t       dv_s8, dv_s9, dv_s10;

	always_ff @(posedge clk) begin
		if (ctrl.ld[S0+1]) begin
			norm_s8 <= norm_s7;
			sat_s8  <= sat_s7;
			g_s8    <= g_s7;
			a_s8    <= a_s7;
			dv_s8   <= step2(dv_s7, a_s7);
		end
		if (ctrl.ld[S0+2]) begin
			norm_s9 <= norm_s8;
			sat_s9  <= sat_s8;
			g_s9    <= g_s8;
			a_s9    <= a_s8;
			dv_s9   <= step2(dv_s8, a_s8);
		end
		if (ctrl.ld[S0+3]) begin
			norm_s10 <= norm_s9;
			sat_s10  <= sat_s9;
			g_s10    <= g_s9;
			a_s10    <= a_s9;
			dv_s10   <= step2(dv_s9, a_s9);
		end
	end

	// Stage 11: last two bits and the output register
	logic [7:0] gray_s11, alpha_s11;
	div_t       dv_last;

	assign dv_last = step2(dv_s10, a_s10);

	always_ff @(posedge clk) begin
		if (ctrl.ld[S0+4]) begin
			alpha_s11 <= a_s10;
			if (!norm_s10) begin
				gray_s11 <= g_s10;
			end else if (sat_s10) begin
				gray_s11 <= 8'(gao_pkg::CHANNEL_MAX);
			end else begin
				gray_s11 <= dv_last.q;
			end
		end
	end

	assign out_gray  = gray_s11;
	assign out_alpha = alpha_s11;

endmodule

/* rtl/gray_alpha_over_compositor.sv */
// Top level of the gray-plus-alpha over compositor.
//
//  channel  dir  handshake             payload
//  s_       in   s_tvalid / s_tready   s_tdata: src_gray, src_alpha, dst_gray, dst_alpha
//  m_       out  m_tvalid / m_tready   m_tdata: out_gray, out_alpha
//  cfg_     in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One pixel pair is taken every clock while the output is not stalled; each result
// passes through eleven register stages (six blend stages, five divider stages
// for un-premultiply).
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up behind a stalled output and a stall drops or repeats nothing.
// Reset clears the valid bits and sets over mode at full opacity.
module gray_alpha_over_compositor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // src_gray, src_alpha, dst_gray, dst_alpha
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_gray, out_alpha
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [1:0]          blend_mode_q;
	logic [7:0]          layer_opacity_q;
	gao_pkg::pipe_ctrl_t ctrl;
	gao_pkg::pix_t       pix;
	logic [7:0]          out_gray, out_alpha;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q    <= gao_pkg::MODE_OVER;
			layer_opacity_q <= 8'(gao_pkg::CHANNEL_MAX);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gao_pkg::CFG_BLEND_MODE: begin
					blend_mode_q <= cfg_data[1:0];
				end
				gao_pkg::CFG_LAYER_OPACITY: begin
					layer_opacity_q <= cfg_data;
				end
				default: begin
					blend_mode_q <= blend_mode_q;
				end
			endcase
		end
	end

	gao_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.ctrl      (ctrl)
	);

	gao_blend u_blend (
		.clk           (clk),
		.ctrl          (ctrl),
		.blend_mode    (blend_mode_q),
		.layer_opacity (layer_opacity_q),
		.src_gray      (s_tdata[7:0]),
		.src_alpha     (s_tdata[15:8]),
		.dst_gray      (s_tdata[23:16]),
		.dst_alpha     (s_tdata[31:24]),
		.pix           (pix)
	);

	gao_unpremul u_unpremul (
		.clk       (clk),
		.ctrl      (ctrl),
		.pix       (pix),
		.out_gray  (out_gray),
		.out_alpha (out_alpha)
	);

	assign m_tdata = {out_alpha, out_gray};

endmodule

/* rtl/gao_checker.sv */
// Port-level checks on the compositor and their attachment to the top level.
module gao_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result word changed while stalled");

	// An empty output stage means the whole pipeline has room
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// A result needs an accepted word, so none follows reset at once
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> ##1 !m_tvalid)
		else $error("result word without input after reset");

	// Configuration is never back-pressured
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind gray_alpha_over_compositor gao_checker u_gao_checker (.*);
